[sv/gmpsc_pkg.sv]
package gmpsc_pkg;

  localparam int unsigned ScoreW = 12;
  localparam int unsigned CountW = 30;

  localparam logic [CountW-1:0] CountMod = 30'd1000000007;
  localparam logic [ScoreW-1:0] ScoreMax = 12'd4095;
  localparam logic [7:0]        SideReset = 8'd2;

  // Cell class codes
  localparam logic [1:0] ClsScore = 2'd0;
  localparam logic [1:0] ClsBlock = 2'd1;
  localparam logic [1:0] ClsStart = 2'd2;

  typedef struct packed {
    logic [1:0] cell_class;
    logic [3:0] cell_score;
  } in_word_t;

  typedef struct packed {
    logic [ScoreW-1:0] best_score;
    logic [CountW-1:0] path_count;
    logic              reachable;
  } out_word_t;

  // One stored cell: reach flag, best score, path count
  typedef struct packed {
    logic              reach;
    logic [ScoreW-1:0] score;
    logic [CountW-1:0] count;
  } cell_entry_t;

  // Position context of the cell being processed
  typedef struct packed {
    logic first;
    logic has_down;
    logic has_right;
  } cell_pos_t;

endpackage

[sv/gmpsc_ram.sv]
module gmpsc_ram #(
  parameter int unsigned WIDTH = 43,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/gmpsc_cell.sv]
module gmpsc_cell import gmpsc_pkg::*; (
  input  logic [1:0]  cell_class_i,
  input  logic [3:0]  cell_score_i,
  input  cell_pos_t   pos_i,
  input  cell_entry_t down_i,
  input  cell_entry_t right_i,
  input  cell_entry_t diag_i,
  output cell_entry_t cell_o
);

  logic              r_down, r_right, r_diag, any_nb;
  logic [ScoreW-1:0] s_down, s_right, s_diag, nb_best;
  logic              e_down, e_right, e_diag;
  logic [CountW+1:0] cnt_sum;
  logic [CountW-1:0] nb_count;
  logic [ScoreW:0]   score_sum;
  logic              open_cell, seeded;
  logic [ScoreW-1:0] base_score;
  logic [CountW-1:0] base_count;

  always_comb begin
    // Only neighbors that exist and are reachable take part
    r_down  = pos_i.has_down & down_i.reach;
    r_right = pos_i.has_right & right_i.reach;
    r_diag  = pos_i.has_down & pos_i.has_right & diag_i.reach;
    any_nb  = r_down | r_right | r_diag;

    s_down  = r_down  ? down_i.score  : '0;
    s_right = r_right ? right_i.score : '0;
    s_diag  = r_diag  ? diag_i.score  : '0;

    nb_best = (s_down > s_right) ? s_down : s_right;
    if (s_diag > nb_best) begin
      nb_best = s_diag;
    end

    e_down  = r_down  && (s_down  == nb_best);
    e_right = r_right && (s_right == nb_best);
    e_diag  = r_diag  && (s_diag  == nb_best);

    // Stored counts are already reduced, so the sum stays below three moduli
    cnt_sum = (e_down  ? {2'b00, down_i.count}  : '0)
            + (e_right ? {2'b00, right_i.count} : '0)
            + (e_diag  ? {2'b00, diag_i.count}  : '0);
    if (cnt_sum >= {1'b0, CountMod, 1'b0}) begin
      cnt_sum = cnt_sum - {1'b0, CountMod, 1'b0};
    end else if (cnt_sum >= {2'b00, CountMod}) begin
      cnt_sum = cnt_sum - {2'b00, CountMod};
    end
    nb_count = cnt_sum[CountW-1:0];

    // The first cell of a grid is seeded with score zero and one path
    seeded     = pos_i.first;
    base_score = seeded ? '0 : nb_best;
    base_count = seeded ? CountW'(1) : nb_count;
    open_cell  = seeded | any_nb;

    score_sum = {1'b0, base_score} + (ScoreW + 1)'(cell_score_i);

    cell_o = '0;
    case (cell_class_i)
      ClsBlock: begin
        cell_o = '0;
      end
      ClsStart: begin
        if (seeded) begin
          cell_o.reach = 1'b1;
          cell_o.score = '0;
          cell_o.count = CountW'(1);
        end
      end
      default: begin
        // Scoring and end cells; the spare class code behaves the same
        if (open_cell) begin
          cell_o.reach = 1'b1;
          cell_o.score = score_sum[ScoreW] ? ScoreMax : score_sum[ScoreW-1:0];
          cell_o.count = base_count;
        end
      end
    endcase
  end

endmodule

[sv/grid_max_path_score_count.sv]
// The result word for a grid becomes valid in the cycle after its top-left cell is taken.
// Throughput: one cell word per cycle; the two-port row store reads the next column
// while the current one is written, so cells stream without gaps. Only the top-left
// cell waits, and only while the previous result word is held and not taken.
// Reset (rst_ni low, asynchronous): grid side returns to 2, position returns to the
// bottom-right cell, neighbor registers clear and no result word is pending.
module grid_max_path_score_count import gmpsc_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned PosW  = $clog2(MAX_SIDE);
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned CmpW  = (SideW > 8) ? SideW : 8;
  localparam int unsigned EntW  = $bits(cell_entry_t);

  // Position within the grid, counted from the bottom-right cell
  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] row_q, row_d;
  logic [7:0]      side_q, side_d;

  // Neighbor holding registers: the cell to the right and the one below-right
  cell_entry_t right_q, right_d;
  cell_entry_t diag_q, diag_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic [CmpW-1:0]  side_ext;
  logic [SideW-1:0] side_eff;
  logic [SideW-1:0] col_inc, row_inc;
  logic             last_col, last_row, last_cell;
  logic             accept;
  cell_pos_t        pos;
  cell_entry_t      down, cur_entry;
  logic [EntW-1:0]  row_rdata;

  // Clamp the programmed side into the supported range
  always_comb begin
    side_ext = CmpW'(side_q);
    if (side_ext < CmpW'(2)) begin
      side_ext = CmpW'(2);
    end else if (side_ext > CmpW'(MAX_SIDE)) begin
      side_ext = CmpW'(MAX_SIDE);
    end
    side_eff = side_ext[SideW-1:0];
  end

  assign col_inc   = SideW'(col_q) + SideW'(1);
  assign row_inc   = SideW'(row_q) + SideW'(1);
  assign last_col  = (col_inc >= side_eff);
  assign last_row  = (row_inc >= side_eff);
  assign last_cell = last_col & last_row;

  // Hold off only the top-left cell while a result word is still waiting
  assign in_ready_o = ~(last_cell & out_valid_q & ~out_ready_i);
  assign accept     = in_valid_i & in_ready_o;

  assign pos.first     = (col_q == '0) && (row_q == '0);
  assign pos.has_down  = (row_q != '0);
  assign pos.has_right = (col_q != '0);

  // Row store holds the row below, one entry per column
  assign down = cell_entry_t'(row_rdata);

  gmpsc_cell u_cell (
    .cell_class_i (in_data_i.cell_class),
    .cell_score_i (in_data_i.cell_score),
    .pos_i        (pos),
    .down_i       (down),
    .right_i      (right_q),
    .diag_i       (diag_q),
    .cell_o       (cur_entry)
  );

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    side_d      = side_q;
    right_d     = right_q;
    diag_d      = diag_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      // A new side abandons any partial grid
      side_d = cfg_wdata_i;
      col_d  = '0;
      row_d  = '0;
    end else if (accept) begin
      right_d = cur_entry;
      diag_d  = down;
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d                = '0;
          out_valid_d          = 1'b1;
          out_d.best_score     = cur_entry.score;
          out_d.path_count     = cur_entry.count;
          out_d.reachable      = cur_entry.reach;
        end else begin
          row_d = row_q + PosW'(1);
        end
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  // Read the column of the next word so its entry is ready when that word arrives;
  // the write goes to the current column, not the read one, as the walk steps on.
  gmpsc_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_SIDE)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (cur_entry),
    .raddr_i (col_d),
    .rdata_o (row_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      side_q      <= SideReset;
      right_q     <= '0;
      diag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      side_q      <= side_d;
      right_q     <= right_d;
      diag_q      <= diag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[verif/tb_grid_max_path_score_count.sv]
`timescale 1ns / 100ps

module tb_grid_max_path_score_count;
  import gmpsc_pkg::*;

  localparam int unsigned MAX_SIDE    = 128;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned SETTLE      = 4;        // result word is registered after the top-left cell
  localparam int unsigned HOLD_CYCLES = 300;      // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Class code 3 has no name in the package; the block treats it as a scoring cell.
  localparam logic [1:0] ClsSpare = 2'd3;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_we      = 1'b0;
  logic [7:0] cfg_wdata  = '0;
  logic      in_valid    = 1'b0;
  in_word_t  in_data     = '0;
  logic      out_ready   = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  grid_max_path_score_count #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Grid predictor: one row of stored cells plus the right and below-right
  // neighbors, walked in reverse raster order exactly as the block walks them.
  // ---------------------------------------------------------------------------
  logic [7:0]  side_reg = SideReset;
  cell_entry_t row_store [MAX_SIDE];
  cell_entry_t right_cell = '0;
  cell_entry_t diag_cell  = '0;
  int unsigned col_at = 0;
  int unsigned row_at = 0;

  out_word_t   corner_results[$];   // expected top-left results, oldest first
  int unsigned grids_finished = 0;
  int unsigned cells_sent     = 0;
  int unsigned mismatches     = 0;

  initial begin
    for (int i = 0; i < MAX_SIDE; i++) row_store[i] = '0;
  end

  function automatic int unsigned side_in_use();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  // Fold one neighbor into the running best: a higher score replaces, an equal
  // score adds its count modulo the prime.
  function automatic void fold_neighbor(inout logic any, inout logic [ScoreW-1:0] best,
                                        inout logic [CountW-1:0] cnt, input cell_entry_t nb);
    logic [CountW:0] sum;
    if (!nb.reach) return;
    if (!any || nb.score > best) begin
      any  = 1'b1;
      best = nb.score;
      cnt  = nb.count;
    end else if (nb.score == best) begin
      sum = {1'b0, cnt} + {1'b0, nb.count};
      if (sum >= {1'b0, CountMod}) sum = sum - {1'b0, CountMod};
      cnt = sum[CountW-1:0];
    end
  endfunction

  task automatic predict_cell(input in_word_t w);
    int unsigned side;
    int unsigned col;
    logic first;
    logic any;
    logic [ScoreW-1:0] best;
    logic [CountW-1:0] cnt;
    logic [ScoreW:0] total;
    cell_entry_t fresh;
    side  = side_in_use();
    col   = (col_at >= side) ? 0 : col_at;
    if (row_at >= side) row_at = 0;
    first = (col == 0) && (row_at == 0);
    any   = 1'b0;
    best  = '0;
    cnt   = '0;
    if (w.cell_class == ClsStart) begin
      // only the bottom-right cell may act as the start
      if (first) begin
        any = 1'b1;
        cnt = CountW'(1);
      end
    end else if (w.cell_class != ClsBlock) begin
      if (first) begin
        any = 1'b1;
        cnt = CountW'(1);
      end else begin
        if (row_at > 0) fold_neighbor(any, best, cnt, row_store[col]);
        if (col > 0) fold_neighbor(any, best, cnt, right_cell);
        if (col > 0 && row_at > 0) fold_neighbor(any, best, cnt, diag_cell);
      end
      if (any) begin
        total = {1'b0, best} + (ScoreW + 1)'(w.cell_score);
        best  = (total > {1'b0, ScoreMax}) ? ScoreMax : total[ScoreW-1:0];
      end
    end
    if (!any) begin
      best = '0;
      cnt  = '0;
    end
    fresh.reach = any;
    fresh.score = best;
    fresh.count = cnt;
    diag_cell       = row_store[col];
    row_store[col]  = fresh;
    right_cell      = fresh;
    if (col + 1 >= side) begin
      col_at = 0;
      if (row_at + 1 >= side) begin
        row_at = 0;
        corner_results.push_back('{best_score: best, path_count: cnt, reachable: any});
        grids_finished++;
      end else begin
        row_at++;
      end
    end else begin
      col_at = col + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  logic src_idle_on  = 1'b0;
  logic sink_idle_on = 1'b0;

  // Offer one cell word; return at the edge that takes it, so the next call can
  // keep valid high without a dip.
  task automatic send_cell(input logic [1:0] cls, input logic [3:0] digit);
    in_word_t w;
    w.cell_class = cls;
    w.cell_score = digit;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_cell(w);
    cells_sent++;
  endtask

  // Drop valid, then hold until every pending result word has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (corner_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the side register; this also restarts the walk at the bottom-right cell.
  task automatic write_side(input logic [7:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    side_reg = value;
    col_at   = 0;
    row_at   = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send the first n_cells of a grid: start cell first, an end cell at the grid's
  // last cell, block_pct percent blocked. Wild grids mix in arbitrary codes and digits.
  task automatic send_grid(input int unsigned side, input int unsigned n_cells,
                           input int unsigned block_pct, input int unsigned max_digit,
                           input logic wild);
    logic [1:0] cls;
    logic [3:0] digit;
    for (int k = 0; k < n_cells; k++) begin
      digit = 4'($urandom_range(0, max_digit));
      if (k == 0) begin
        cls = ClsStart;
      end else if (k == side * side - 1) begin
        cls   = ClsScore;
        digit = '0;
      end else if ($urandom_range(0, 99) < block_pct) begin
        cls = ClsBlock;
      end else begin
        cls = ($urandom_range(0, 9) == 0) ? ClsSpare : ClsScore;
      end
      if (wild && $urandom_range(0, 3) == 0) begin
        cls   = 2'($urandom_range(0, 3));
        digit = 4'($urandom_range(0, 15));
      end
      send_cell(cls, digit);
    end
  endtask

  function automatic logic [7:0] pick_side();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 8'($urandom_range(0, 1));
    if (roll < 60) return 8'($urandom_range(2, 5));
    if (roll < 90) return 8'($urandom_range(6, 10));
    return 8'($urandom_range(11, 16));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  event hold_ev;
  logic long_hold = 1'b0;

  initial begin
    forever begin
      @(hold_ev);
      @(posedge clk);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every taken word against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(input string field, input longint unsigned want,
                                          input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (corner_results.size() == 0) begin
        report_mismatch("unexpected result word, best_score", 0, out_data.best_score);
      end else begin
        want = corner_results.pop_front();
        if (out_data.best_score !== want.best_score)
          report_mismatch("best_score", want.best_score, out_data.best_score);
        if (out_data.path_count !== want.path_count)
          report_mismatch("path_count", want.path_count, out_data.path_count);
        if (out_data.reachable !== want.reachable)
          report_mismatch("reachable", want.reachable, out_data.reachable);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Use the reset side of 2: max digit, class 3 scoring cell, end cell.
  task automatic test_reset_side();
    send_cell(ClsStart, 4'd0);
    send_cell(ClsScore, 4'd15);
    send_cell(ClsSpare, 4'd9);
    send_cell(ClsScore, 4'd0);
  endtask

  // Cover the bottom-right cell cases; sides below 2 act as 2.
  task automatic test_first_cell();
    write_side(8'd0);
    // blocked start: nothing reaches the corner
    send_cell(ClsBlock, 4'd9);
    send_cell(ClsScore, 4'd9);
    send_cell(ClsScore, 4'd9);
    send_cell(ClsScore, 4'd0);
    write_side(8'd1);
    // scoring first cell adds its own digit
    send_cell(ClsScore, 4'd7);
    send_cell(ClsScore, 4'd3);
    send_cell(ClsScore, 4'd1);
    send_cell(ClsScore, 4'd0);
    // start code away from the first cell is unreachable
    send_cell(ClsStart, 4'd0);
    send_cell(ClsStart, 4'd5);
    send_cell(ClsScore, 4'd5);
    send_cell(ClsScore, 4'd0);
  endtask

  // Drop a partial grid with a side write, then run a full one.
  task automatic test_abandon();
    write_side(8'd3);
    send_cell(ClsStart, 4'd0);
    send_cell(ClsScore, 4'd8);
    write_side(8'd3);
    send_cell(ClsStart, 4'd0);
    send_cell(ClsScore, 4'd2);
    send_cell(ClsBlock, 4'd4);
    send_cell(ClsScore, 4'd2);
    send_cell(ClsScore, 4'd0);
    send_cell(ClsScore, 4'd1);
    send_cell(ClsScore, 4'd15);
    send_cell(ClsBlock, 4'd0);
    send_cell(ClsScore, 4'd0);
  endtask

  // Widest rows on partial grids (255 acts as 128), then a 14-wide grid of zero
  // digits whose path count wraps the modulus.
  task automatic test_max_side();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    write_side(8'd128);
    send_grid(MAX_SIDE, MAX_SIDE + 3, 0, 9, 1'b0);
    write_side(8'd255);
    send_grid(MAX_SIDE, 2 * MAX_SIDE, 5, 9, 1'b0);
    write_side(8'd14);
    send_grid(14, 14 * 14, 0, 0, 1'b0);
  endtask

  // Hold the receiver off while small grids keep coming, so the input stalls.
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_side(8'd2);
    -> hold_ev;
    for (int g = 0; g < 40; g++) send_grid(2, 4, 10, 9, 1'b0);
    wait_idle();
  endtask

  // Mostly well-formed grids of random sizes; some wild, some cut short.
  task automatic test_random();
    int unsigned side;
    int unsigned mode;
    while (cells_sent < 850 || grids_finished < 50) begin
      mode         = $urandom_range(0, 3);
      src_idle_on  = mode[0];
      sink_idle_on = mode[1];
      if ($urandom_range(0, 4) == 0) write_side(pick_side());
      side = side_in_use();
      if ($urandom_range(0, 9) == 0) begin
        send_grid(side, $urandom_range(1, side * side - 1), $urandom_range(0, 40), 9,
                  1'($urandom_range(0, 1)));
        write_side(pick_side());
      end else begin
        send_grid(side, side * side, $urandom_range(0, 40),
                  ($urandom_range(0, 4) == 0) ? 15 : 9, $urandom_range(0, 6) == 0);
      end
    end
  endtask

  // Stream back-to-back grids with no idling on either side.
  task automatic test_streaming();
    int unsigned side;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int g = 0; g < 10; g++) begin
      if (g % 5 == 0) write_side(8'($urandom_range(2, 6)));
      side = side_in_use();
      send_grid(side, side * side, $urandom_range(0, 30), 9, 1'b0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_side();
    test_first_cell();
    test_abandon();
    test_max_side();
    test_backpressure();
    test_random();
    test_streaming();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && corner_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
